// ===== rtl/trimmed_mean_drop_two_each_end_defines.svh =====
// Assertion helpers for the trimmed mean block
`ifndef TRIMMED_MEAN_DROP_TWO_EACH_END_DEFINES_SVH
`define TRIMMED_MEAN_DROP_TWO_EACH_END_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define TMD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define TMD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/tmd_pkg.sv =====
package tmd_pkg;

    localparam int DATA_W    = 32;
    localparam int SUM_W     = 40;
    localparam int CNT_W     = 8;
    localparam int DIVISOR_W = 8;
    localparam int DIV_STEPS = SUM_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);
    localparam int TRIM_N    = 4;
    localparam int MIN_SET   = 5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TRIM,
        ST_PREP,
        ST_DIV,
        ST_FINISH
    } state_t;

    // extremes removed from the sum, one per trim cycle
    typedef enum logic [1:0] {
        SEL_LOW0,
        SEL_LOW1,
        SEL_HIGH0,
        SEL_HIGH1
    } trim_sel_t;

    typedef struct packed {
        logic      accept;
        logic      trim;
        trim_sel_t sel;
        logic      prep;
        logic      step;
        logic      finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic short_set;
    } dp_stat_t;

endpackage

// ===== rtl/tmd_ctrl.sv =====
module tmd_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               last,
    input  tmd_pkg::dp_stat_t  stat,
    output tmd_pkg::ctrl_cmd_t cmd,
    output logic               busy,
    output logic               done
);
    import tmd_pkg::*;

    state_t            state_reg, state_next;
    logic [1:0]        trim_cnt_reg, trim_cnt_next;
    logic [STEP_W-1:0] step_cnt_reg, step_cnt_next;
    logic              done_reg, done_next;

    localparam logic [1:0]        TRIM_LAST = 2'(TRIM_N - 1);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIV_STEPS - 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            trim_cnt_reg <= '0;
            step_cnt_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            trim_cnt_reg <= trim_cnt_next;
            step_cnt_reg <= step_cnt_next;
            done_reg     <= done_next;
        end
    end

    // next state and sequencing counters
    always_comb
    begin
        state_next    = state_reg;
        trim_cnt_next = trim_cnt_reg;
        step_cnt_next = step_cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                trim_cnt_next = '0;
                if (start && last)
                    state_next = ST_TRIM;
            end
            ST_TRIM:
            begin
                trim_cnt_next = trim_cnt_reg + 2'd1;
                if (stat.short_set)
                    state_next = ST_FINISH;
                else if (trim_cnt_reg == TRIM_LAST)
                    state_next = ST_PREP;
            end
            ST_PREP:
            begin
                step_cnt_next = '0;
                state_next    = ST_DIV;
            end
            ST_DIV:
            begin
                step_cnt_next = step_cnt_reg + STEP_W'(1);
                if (step_cnt_reg == STEP_LAST)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // commands to the datapath
    always_comb
    begin
        cmd       = '0;
        cmd.sel   = trim_sel_t'(trim_cnt_reg);
        busy      = 1'b1;
        done_next = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy       = 1'b0;
                cmd.accept = start;
            end
            ST_TRIM:   cmd.trim = 1'b1;
            ST_PREP:   cmd.prep = 1'b1;
            ST_DIV:    cmd.step = 1'b1;
            ST_FINISH:
            begin
                cmd.finish = 1'b1;
                done_next  = 1'b1;
            end
            default:   busy = 1'b1;
        endcase
    end

    assign done = done_reg;

endmodule

// ===== rtl/tmd_dp.sv =====
module tmd_dp #(
    parameter int MAX_COUNT = 255
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  tmd_pkg::ctrl_cmd_t                  cmd,
    input  logic signed [tmd_pkg::DATA_W-1:0]   sample,
    output tmd_pkg::dp_stat_t                   stat,
    output logic signed [tmd_pkg::DATA_W-1:0]   mean,
    output logic                                too_few
);
    import tmd_pkg::*;

    localparam logic signed [DATA_W-1:0] POS_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] NEG_MAX = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic [CNT_W-1:0]         CNT_MAX = CNT_W'(MAX_COUNT);
    localparam logic [CNT_W-1:0]         CNT_MIN = CNT_W'(MIN_SET);
    localparam logic [CNT_W-1:0]         CNT_TRIM = CNT_W'(TRIM_N);

    logic signed [SUM_W-1:0]  sum_reg, sum_next;
    logic signed [DATA_W-1:0] low0_reg, low0_next, low1_reg, low1_next;
    logic signed [DATA_W-1:0] high0_reg, high0_next, high1_reg, high1_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [SUM_W-1:0]         quo_reg, quo_next;
    logic [DIVISOR_W-1:0]     rem_reg, rem_next;
    logic [DIVISOR_W-1:0]     dvs_reg, dvs_next;
    logic                     neg_reg, neg_next;
    logic signed [DATA_W-1:0] mean_reg, mean_next;
    logic                     too_few_reg, too_few_next;

    logic signed [DATA_W-1:0] trim_val;
    logic [DIVISOR_W:0]       trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg     <= '0;
            low0_reg    <= POS_MAX;
            low1_reg    <= POS_MAX;
            high0_reg   <= NEG_MAX;
            high1_reg   <= NEG_MAX;
            count_reg   <= '0;
            too_few_reg <= 1'b0;
        end
        else
        begin
            sum_reg     <= sum_next;
            low0_reg    <= low0_next;
            low1_reg    <= low1_next;
            high0_reg   <= high0_next;
            high1_reg   <= high1_next;
            count_reg   <= count_next;
            too_few_reg <= too_few_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
        neg_reg  <= neg_next;
        mean_reg <= mean_next;
    end

    always_comb
    begin
        case (cmd.sel)
            SEL_LOW0:  trim_val = low0_reg;
            SEL_LOW1:  trim_val = low1_reg;
            SEL_HIGH0: trim_val = high0_reg;
            SEL_HIGH1: trim_val = high1_reg;
            default:   trim_val = low0_reg;
        endcase
    end

    assign trial = {rem_reg, quo_reg[SUM_W-1]};

    always_comb
    begin
        sum_next     = sum_reg;
        low0_next    = low0_reg;
        low1_next    = low1_reg;
        high0_next   = high0_reg;
        high1_next   = high1_reg;
        count_next   = count_reg;
        quo_next     = quo_reg;
        rem_next     = rem_reg;
        dvs_next     = dvs_reg;
        neg_next     = neg_reg;
        mean_next    = mean_reg;
        too_few_next = too_few_reg;

        if (cmd.accept && (count_reg < CNT_MAX))
        begin
            sum_next   = sum_reg + SUM_W'(sample);
            count_next = count_reg + CNT_W'(1);
            if (sample < low0_reg)
            begin
                low1_next = low0_reg;
                low0_next = sample;
            end
            else if (sample < low1_reg)
                low1_next = sample;
            if (sample > high0_reg)
            begin
                high1_next = high0_reg;
                high0_next = sample;
            end
            else if (sample > high1_reg)
                high1_next = sample;
        end

        if (cmd.trim)
            sum_next = sum_reg - SUM_W'(trim_val);

        // divide magnitudes, fix the sign at the end for truncation toward zero
        if (cmd.prep)
        begin
            neg_next = sum_reg[SUM_W-1];
            quo_next = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
            rem_next = '0;
            dvs_next = DIVISOR_W'(count_reg - CNT_TRIM);
        end

        if (cmd.step)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = DIVISOR_W'(trial - {1'b0, dvs_reg});
                quo_next = {quo_reg[SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DIVISOR_W-1:0];
                quo_next = {quo_reg[SUM_W-2:0], 1'b0};
            end
        end

        if (cmd.finish)
        begin
            too_few_next = stat.short_set;
            if (stat.short_set)
                mean_next = '0;
            else if (neg_reg)
                mean_next = -$signed(quo_reg[DATA_W-1:0]);
            else
                mean_next = $signed(quo_reg[DATA_W-1:0]);
            sum_next   = '0;
            low0_next  = POS_MAX;
            low1_next  = POS_MAX;
            high0_next = NEG_MAX;
            high1_next = NEG_MAX;
            count_next = '0;
        end
    end

    assign stat.short_set = (count_reg < CNT_MIN);
    assign mean           = mean_reg;
    assign too_few        = too_few_reg;

endmodule

// ===== rtl/trimmed_mean_drop_two_each_end.sv =====
// Trimmed mean: drops the two smallest and two largest samples, averages the rest.
// Samples are taken one per cycle while busy is low; the word with last closes the set.
// After the closing word come 4 trim, 1 prep, 40 divide steps of the bit-serial
// divider and 1 finish step, then done pulses; a set under five goes from trim to
// finish. busy is high until done; the unstallable result holds to the next finish.
// rst_n clears all accumulator and sequencer state asynchronously.
`include "trimmed_mean_drop_two_each_end_defines.svh"

module trimmed_mean_drop_two_each_end #(
    parameter int MAX_COUNT = 255
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic signed [tmd_pkg::DATA_W-1:0] sample,
    input  logic                              last,
    output logic                              busy,
    output logic                              done,
    output logic signed [tmd_pkg::DATA_W-1:0] mean,
    output logic                              too_few
);
    import tmd_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    tmd_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .last  (last),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    tmd_dp #(
        .MAX_COUNT (MAX_COUNT)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .sample  (sample),
        .stat    (stat),
        .mean    (mean),
        .too_few (too_few)
    );

    `TMD_ASSERT_NOW(a_done_after_busy, done, $past(busy), "result without a busy cycle")
    `TMD_ASSERT_NOW(a_short_mean_zero, done && too_few, mean == '0, "short set mean not zero")
    `TMD_ASSERT_NEXT(a_last_sets_busy, start && !busy && last, busy, "closing word not processed")

endmodule
